[design/mtbud_pkg.sv]
// Shared constants and helpers for the bounded uniform draw block.
// Holds the twister geometry, the tempering function and the init multiplier.
// No dependencies.
`default_nettype none

package mtbud_pkg;

  // twister geometry
  localparam int unsigned N_WORDS = 624;
  localparam int unsigned M_OFFSET = 397;
  localparam int unsigned POS_W = 10;

  localparam logic [31:0] MATRIX_A = 32'h9908_B0DF;
  localparam logic [31:0] INIT_MULT = 32'd1812433253;
  localparam logic [30:0] RESET_SEED = 31'd5489;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(N_WORDS - 1);
  localparam logic [POS_W-1:0] WRAP_POS = POS_W'(N_WORDS - M_OFFSET);
  localparam logic [POS_W-1:0] FAR_STEP = POS_W'(M_OFFSET);

  // standard output tempering
  function automatic logic [31:0] temper(logic [31:0] x);
    logic [31:0] y;
    y = x ^ (x >> 11);
    y = y ^ ((y << 7) & 32'h9D2C_5680);
    y = y ^ ((y << 15) & 32'hEFC6_0000);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

`default_nettype wire

[design/mtbud_ram.sv]
// Generic synchronous RAM: one write port and two registered read ports.
// Holds the twister state words. No dependencies.
`default_nettype none

module mtbud_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 624
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic      [WIDTH-1:0]         ra_data,
  input  wire logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic      [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

`default_nettype wire

[design/mt19937_bounded_uniform_draw.sv]
// Top level: MT19937 draw engine with bitmask rejection for a bounded result.
// Uses mtbud_pkg and one mtbud_ram instance for the 624-word state.
//
// Each s_tdata item is an inclusive bound; one m_tdata item comes back with a
// uniform integer in [0, bound]. The state lives in a two-read-port RAM and is
// regenerated lazily, one word per draw: a draw reads the next and the far
// word in its read state and writes the new word and tempers it in the
// write-back state that follows. An item goes through a setup state, then a
// read and a write-back state per drawn word, then delivery, which waits
// while the output is still held (rejection averages under two draws; a
// bound of 0 draws nothing). After reset and after every seed write an
// initialization sweep fills the state, during which no item is accepted;
// each init word goes through the one 32x32 multiplier.
`default_nettype none

module mt19937_bounded_uniform_draw (
  input  wire logic        clk,
  input  wire logic        rst,
  // input item: [31:0] max_value
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,
  // result item: [31:0] value
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [31:0] m_tdata,
  // configuration
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  import mtbud_pkg::*;

  localparam logic [2:0] S_INIT0    = 3'd0;
  localparam logic [2:0] S_INIT_MUL = 3'd1;
  localparam logic [2:0] S_INIT_WR  = 3'd2;
  localparam logic [2:0] S_IDLE     = 3'd3;
  localparam logic [2:0] S_PREP     = 3'd4;
  localparam logic [2:0] S_RD       = 3'd5;
  localparam logic [2:0] S_WB       = 3'd6;

  localparam logic REG_SEED = 1'b0;

  // shift amount from a smeared bound mask: 32 minus the bit length
  function automatic logic [5:0] shift_of(logic [31:0] m);
    logic [5:0] s;
    s = 6'd32;
    for (int i = 0; i < 31; i++) begin
      if (m[i] && !m[i+1]) begin
        s = 6'(31 - i);
      end
    end
    if (m[31]) begin
      s = 6'd0;
    end
    return s;
  endfunction

  logic [2:0]        st;
  logic [30:0]       seed;
  logic [POS_W-1:0]  pos;
  logic [POS_W-1:0]  idx;
  logic [31:0]       prev;       // last init word
  logic [31:0]       prod;       // registered init product
  logic [31:0]       cur;        // old value of word at pos
  logic [31:0]       bound;
  logic [31:0]       mask;
  logic [5:0]        sh;
  logic [31:0]       cand;       // tempered candidate
  logic              have_word;

  logic              seed_wr;
  logic              in_acc;
  logic [POS_W-1:0]  nxt_pos;
  logic [POS_W-1:0]  far_pos;
  logic [31:0]       rd_nxt;
  logic [31:0]       rd_far;
  logic [31:0]       y_mix;
  logic [31:0]       new_word;
  logic [31:0]       init_word;
  logic [31:0]       shifted;
  logic              fits;
  logic              out_free;
  logic              ram_we;
  logic [POS_W-1:0]  ram_waddr;
  logic [31:0]       ram_wdata;
  logic [31:0]       smear;

  assign pready   = 1'b1;
  assign seed_wr  = psel && penable && pwrite && (paddr[2] == REG_SEED);
  assign prdata   = (paddr[2] == REG_SEED) ? {1'b0, seed} : 32'd0;
  assign s_tready = (st == S_IDLE);
  assign in_acc   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // neighbor addresses for lazy regeneration
  assign nxt_pos = (pos == LAST_POS) ? '0 : pos + POS_W'(1);
  assign far_pos = (pos >= WRAP_POS) ? pos - WRAP_POS : pos + FAR_STEP;

  // twist of one word
  assign y_mix    = {cur[31], rd_nxt[30:0]};
  assign new_word = rd_far ^ (y_mix >> 1) ^ (y_mix[0] ? MATRIX_A : 32'd0);

  assign init_word = prod + {{(32-POS_W){1'b0}}, idx};

  // rejection test on the held candidate
  assign shifted = cand >> sh;
  assign fits    = have_word && (shifted <= bound);

  assign smear = s_tdata | (s_tdata >> 1) | (s_tdata >> 2) | (s_tdata >> 3)
               | (s_tdata >> 4) | (s_tdata >> 8) | (s_tdata >> 12)
               | (s_tdata >> 16) | (s_tdata >> 20) | (s_tdata >> 24)
               | (s_tdata >> 28);

  // RAM write port selection
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos;
    ram_wdata = new_word;
    case (st)
      S_INIT0: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {1'b0, seed};
      end
      S_INIT_WR: begin
        ram_we    = 1'b1;
        ram_waddr = idx;
        ram_wdata = init_word;
      end
      S_WB: begin
        ram_we = 1'b1;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  mtbud_ram #(
    .WIDTH(32),
    .DEPTH(N_WORDS)
  ) u_state (
    .clk    (clk),
    .we     (ram_we),
    .waddr  (ram_waddr),
    .wdata  (ram_wdata),
    .ra_addr(nxt_pos),
    .ra_data(rd_nxt),
    .rb_addr(far_pos),
    .rb_data(rd_far)
  );

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      st        <= S_INIT0;
      seed      <= RESET_SEED;
      pos       <= '0;
      idx       <= '0;
      have_word <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      // result valid: set when a fitting value goes out, cleared when taken
      if (st == S_RD && fits && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (seed_wr) begin
        // a seed write restarts the init sweep
        seed <= pwdata[30:0];
        st   <= S_INIT0;
      end else begin
        case (st)
          S_INIT0: begin
            idx <= POS_W'(1);
            st  <= S_INIT_MUL;
          end
          S_INIT_MUL: begin
            st <= S_INIT_WR;
          end
          S_INIT_WR: begin
            idx <= idx + POS_W'(1);
            if (idx == LAST_POS) begin
              pos <= '0;
              st  <= S_IDLE;
            end else begin
              st <= S_INIT_MUL;
            end
          end
          S_IDLE: begin
            if (in_acc) begin
              have_word <= (s_tdata == 32'd0);
              st        <= S_PREP;
            end
          end
          S_PREP: begin
            st <= S_RD;
          end
          S_RD: begin
            if (fits) begin
              if (out_free) begin
                st <= S_IDLE;
              end
            end else begin
              st <= S_WB;
            end
          end
          S_WB: begin
            pos       <= nxt_pos;
            have_word <= 1'b1;
            st        <= S_RD;
          end
          default: begin
            st <= S_INIT0;
          end
        endcase
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (st)
      S_INIT0: begin
        prev <= {1'b0, seed};
        cur  <= {1'b0, seed};
      end
      S_INIT_MUL: begin
        prod <= 32'(INIT_MULT * (prev ^ (prev >> 30)));
      end
      S_INIT_WR: begin
        prev <= init_word;
      end
      S_IDLE: begin
        if (in_acc) begin
          bound <= s_tdata;
          mask  <= smear;
          cand  <= 32'd0;
        end
      end
      S_PREP: begin
        sh <= shift_of(mask);
      end
      S_RD: begin
        if (fits && out_free) begin
          m_tdata <= shifted;
        end
      end
      S_WB: begin
        cur  <= rd_nxt;
        cand <= temper(new_word);
      end
      default: begin
      end
    endcase
  end

  // checks
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    pos <= LAST_POS)
    else $error("state position out of range");

  a_pos_step: assert property (@(posedge clk) disable iff (rst)
    (st == S_WB && !seed_wr) |=>
      (pos == (($past(pos) == LAST_POS) ? '0 : $past(pos) + POS_W'(1))))
    else $error("position did not advance by one word");

  a_result_bound: assert property (@(posedge clk) disable iff (rst)
    (st == S_RD && fits && out_free && !seed_wr) |=> (m_tdata <= bound))
    else $error("result above bound");

  a_init_done: assert property (@(posedge clk) disable iff (rst)
    (st == S_INIT_WR && idx == LAST_POS && !seed_wr) |=>
      (st == S_IDLE && pos == '0))
    else $error("init sweep did not end at position zero");

endmodule

`default_nettype wire
